>>> sv/per_source_rate_monitor_macros.svh
// Assertion macros for the per-source rate monitor
`ifndef PER_SOURCE_RATE_MONITOR_MACROS_SVH
`define PER_SOURCE_RATE_MONITOR_MACROS_SVH
`ifndef SYNTH
`define PSRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSRM_ASSERT_IMP(lbl, ante, cons)
`define PSRM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/psrm_pkg.sv
// Types and constants shared by the rate monitor modules
package psrm_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int RATE_W  = 32;
  localparam int WIN_W   = 16;
  localparam int PROD_W  = 42;  // 2^32 * 1000 fits in 42 bits
  localparam int DIVC_W  = 6;
  localparam logic [PROD_W-1:0] MS_PER_S = PROD_W'(1000);

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_FORGET = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_REC_WR,
    S_MUL,
    S_DIV,
    S_EVAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  events;
    logic              ignored;
    logic [RATE_W-1:0] rep_rate;
  } entry_t;

endpackage

>>> sv/psrm_ram.sv
// Generic single-write, registered-read RAM
module psrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/psrm_div.sv
// Bit-serial restoring divider for the rate calculation
module psrm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [psrm_pkg::PROD_W-1:0] num,
  input  logic [psrm_pkg::WIN_W-1:0]  den,
  output logic                      done,
  output logic [psrm_pkg::PROD_W-1:0] quot
);
  import psrm_pkg::*;

  logic [WIN_W-1:0]  rem_r;
  logic [WIN_W-1:0]  den_r;
  logic [PROD_W-1:0] q_r;
  logic [DIVC_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WIN_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, q_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIVC_W'(PROD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= ge ? WIN_W'(trial - {1'b0, den_r}) : WIN_W'(trial);
      q_r   <= {q_r[PROD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> sv/per_source_rate_monitor.sv
// Top level of the per-source rate monitor
// Keeps up to TABLE_ENTRIES source counters in one RAM (key, count, ignored flag, last
// reported rate) with a valid flop per entry. Record and forget scan the table one entry
// at a time (RAM read then compare); clear drops every valid flag without a scan. A
// sample runs each valid entry through the one-bit-per-cycle 42-bit divider, skips empty
// entries, and waits while the result word is held back by out_ready. Entries never
// written are never used, so no clearing pass runs after reset. The input is taken only
// when the previous item is done.
`include "per_source_rate_monitor_macros.svh"
module per_source_rate_monitor #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_source_key,
  input  logic        in_ignored_in,
  input  logic [15:0] in_window_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [31:0] out_entry_key,
  output logic [31:0] out_rate,
  output logic [31:0] out_event_count,
  output logic        out_ignored_out,
  output logic        out_report,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import psrm_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r;
  cmd_t                     cmd_r;
  logic [KEY_W-1:0]         key_r;
  logic                     ign_r;
  logic [WIN_W-1:0]         win_r;
  logic                     hit_r;
  logic                     free_r;
  logic [IDX_W-1:0]         free_idx_r;
  entry_t                   ent_r;
  logic [PROD_W-1:0]        prod_r;
  logic [RATE_W-1:0]        rate_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              min_delta_r;

  logic              res_status_r, res_ign_r, res_rep_r, res_last_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [RATE_W-1:0] res_rate_r;
  logic [CNT_W-1:0]  res_count_r;

  logic              out_valid_r, out_status_r, out_ign_r, out_rep_r, out_last_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;
  logic [$bits(entry_t)-1:0] mem_rbits;

  logic              div_start, div_done;
  logic [PROD_W-1:0] div_quot;

  logic              in_acc, out_load, idx_last, match;
  logic [RATE_W-1:0] prev, delta, thr, new_rep;
  logic              rep;
  logic [TABLE_ENTRIES-1:0] above;

  psrm_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (mem_rbits)
  );
  assign mem_rdata = entry_t'(mem_rbits);

  psrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r + PROD_W'(win_r >> 1)),
    .den   (win_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign idx_last = (idx_r == IDX_LAST);
  assign match    = valid_r[idx_r] && (mem_rdata.key == key_r);
  assign above    = (valid_r >> idx_r) >> 1;

  // report decision for the entry under evaluation
  always_comb begin
    prev    = ent_r.rep_rate;
    delta   = (rate_r > prev) ? rate_r - prev : prev - rate_r;
    thr     = (min_delta_r > (prev >> 2)) ? min_delta_r : (prev >> 2);
    if (rate_r == '0) begin
      rep = (prev != '0);
    end else if (prev == '0) begin
      rep = 1'b1;
    end else begin
      rep = (delta >= thr);
    end
    new_rep = (rate_r == '0) ? '0 : (rep ? rate_r : prev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '{key: ent_r.key, events: '0, ignored: ent_r.ignored, rep_rate: new_rep};
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_command))
            CMD_CLEAR:  state_nxt = S_IDLE;
            CMD_SAMPLE: state_nxt = (in_window_ms == '0 || valid_r == '0) ? S_IDLE : S_RD;
            default:    state_nxt = S_RD;
          endcase
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        case (cmd_r)
          CMD_RECORD: state_nxt = (match || idx_last) ? S_REC_WR : S_RD;
          CMD_FORGET: state_nxt = (match || idx_last) ? S_IDLE : S_RD;
          default: begin
            if (valid_r[idx_r]) begin
              state_nxt = S_MUL;
            end else begin
              state_nxt = idx_last ? S_IDLE : S_RD;
            end
          end
        endcase
      end
      S_REC_WR: begin
        if (hit_r) begin
          mem_we    = 1'b1;
          mem_wdata = '{key: key_r,
                        events: (ent_r.events == '1) ? ent_r.events : ent_r.events + 1'b1,
                        ignored: ign_r, rep_rate: ent_r.rep_rate};
          state_nxt = S_IDLE;
        end else if (free_r) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_r;
          mem_wdata = '{key: key_r, events: CNT_W'(1), ignored: ign_r, rep_rate: '0};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: state_nxt = div_done ? S_EVAL : S_DIV;
      S_EVAL: begin
        mem_we    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = res_last_r ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // valid flags and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      min_delta_r <= 32'd10;
    end else begin
      if (cfg_wr_en) begin
        min_delta_r <= cfg_wr_data;
      end
      if (in_acc && cmd_t'(in_command) == CMD_CLEAR) begin
        valid_r <= '0;
      end
      if (state_r == S_CHK && cmd_r == CMD_FORGET && match) begin
        valid_r[idx_r] <= 1'b0;
      end
      if (state_r == S_REC_WR && !hit_r && free_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      // free stopped entries once sampled
      if (state_r == S_EVAL && rate_r == '0) begin
        valid_r[idx_r] <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (in_acc) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      if (state_r == S_CHK) begin
        if (match) begin
          hit_r <= 1'b1;
        end else if (!valid_r[idx_r] && !free_r) begin
          free_r <= 1'b1;
        end
        if (!(match && cmd_r != CMD_SAMPLE) && !(valid_r[idx_r] && cmd_r == CMD_SAMPLE)) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (out_load && !res_last_r) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_t'(in_command);
      key_r <= in_source_key;
      ign_r <= in_ignored_in;
      win_r <= in_window_ms;
    end
    if (state_r == S_CHK) begin
      ent_r  <= mem_rdata;
      prod_r <= PROD_W'(mem_rdata.events) * MS_PER_S;
      if (!valid_r[idx_r] && !free_r) begin
        free_idx_r <= idx_r;
      end
    end
    if (div_done) begin
      rate_r <= (div_quot[PROD_W-1:RATE_W] != '0) ? '1 : div_quot[RATE_W-1:0];
    end
    if (state_r == S_REC_WR) begin
      res_status_r <= 1'b1;
      res_key_r    <= key_r;
      res_rate_r   <= '0;
      res_count_r  <= '0;
      res_ign_r    <= 1'b0;
      res_rep_r    <= 1'b0;
      res_last_r   <= 1'b1;
    end
    if (state_r == S_EVAL) begin
      res_status_r <= 1'b0;
      res_key_r    <= ent_r.key;
      res_rate_r   <= rate_r;
      res_count_r  <= ent_r.events;
      res_ign_r    <= ent_r.ignored;
      res_rep_r    <= rep;
      res_last_r   <= (above == '0);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_rate_r   <= res_rate_r;
      out_count_r  <= res_count_r;
      out_ign_r    <= res_ign_r;
      out_rep_r    <= res_rep_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_key   = out_key_r;
  assign out_rate        = out_rate_r;
  assign out_event_count = out_count_r;
  assign out_ignored_out = out_ign_r;
  assign out_report      = out_rep_r;
  assign out_last        = out_last_r;

  `PSRM_ASSERT_IMP(a_wr_state, mem_we, state_r == S_REC_WR || state_r == S_EVAL)
  `PSRM_ASSERT_IMP(a_div_state, div_done, state_r == S_DIV)
  `PSRM_ASSERT_IMP(a_drop_last, out_valid_r && out_status_r, out_last_r && !out_rep_r)
  `PSRM_ASSERT_NXT(a_emit_idle, out_load && res_last_r, state_r == S_IDLE)

endmodule

>>> bench/per_source_rate_monitor_test.sv
// Self-checking bench for the per-source rate monitor: directed and random words
`timescale 1ns / 100ps
module per_source_rate_monitor_test;
  import psrm_pkg::*;

  localparam int ENTRIES = 16;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

  typedef struct {
    logic        status;
    logic [31:0] key;
    logic [31:0] rate;
    logic [31:0] count;
    logic        ignored;
    logic        report;
    logic        last;
  } rate_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_RECORD;
  logic [31:0] in_source_key = '0;
  logic        in_ignored_in = 1'b0;
  logic [15:0] in_window_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [31:0] out_entry_key;
  logic [31:0] out_rate;
  logic [31:0] out_event_count;
  logic        out_ignored_out;
  logic        out_report;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // bench copy of the table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_key [ENTRIES];
  logic [31:0] tbl_events [ENTRIES];
  logic        tbl_ignored [ENTRIES];
  logic [31:0] tbl_rep_rate [ENTRIES];
  logic [31:0] min_delta_copy;

  rate_result_t pending_results[$];
  int  fail_count = 0;
  bit  hold_off = 1'b0;
  bit  drive_on = 1'b0;
  logic [31:0] key_pool [8];

  per_source_rate_monitor #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("per_source_rate_monitor_test: FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    rate_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result key=%h", out_entry_key);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_status); fail_count++;
        end
        if (out_entry_key !== want.key) begin
          $error("entry_key exp %h got %h", want.key, out_entry_key); fail_count++;
        end
        if (out_rate !== want.rate) begin
          $error("rate exp %0d got %0d", want.rate, out_rate); fail_count++;
        end
        if (out_event_count !== want.count) begin
          $error("event_count exp %0d got %0d", want.count, out_event_count); fail_count++;
        end
        if (out_ignored_out !== want.ignored) begin
          $error("ignored_out exp %0d got %0d", want.ignored, out_ignored_out); fail_count++;
        end
        if (out_report !== want.report) begin
          $error("report exp %0d got %0d", want.report, out_report); fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last exp %0d got %0d", want.last, out_last); fail_count++;
        end
      end
    end
  end

  function automatic int find_entry(logic [31:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  // work out the results of one word and advance the table copy
  function automatic void predict_rates(cmd_t cmd, logic [31:0] key, logic ign,
                                        logic [15:0] win);
    int s;
    int final_idx;
    logic [63:0] r64;
    logic [31:0] rate, prev, delta, thr;
    logic rep;
    rate_result_t res;
    final_idx = -1;
    case (cmd)
      CMD_RECORD: begin
        s = find_entry(key);
        if (s < 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i]) begin s = i; break; end
          if (s < 0) begin
            res = '{1'b1, key, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1};
            pending_results.push_back(res);
            return;
          end
          tbl_valid[s] = 1'b1;
          tbl_key[s] = key;
          tbl_events[s] = '0;
          tbl_rep_rate[s] = '0;
        end
        if (tbl_events[s] != 32'hFFFF_FFFF) tbl_events[s]++;
        tbl_ignored[s] = ign;
      end
      CMD_FORGET: begin
        s = find_entry(key);
        if (s >= 0) tbl_valid[s] = 1'b0;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      end
      default: begin
        if (win == 0) return;
        for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) final_idx = i;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!tbl_valid[i]) continue;
          r64 = (64'(tbl_events[i]) * 64'd1000 + 64'(win / 2)) / 64'(win);
          rate = (r64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r64[31:0];
          prev = tbl_rep_rate[i];
          if (rate == 0) begin
            rep = (prev != 0);
            tbl_rep_rate[i] = '0;
          end else if (prev == 0) begin
            rep = 1'b1;
          end else begin
            delta = (rate > prev) ? rate - prev : prev - rate;
            thr = prev / 4;
            if (min_delta_copy > thr) thr = min_delta_copy;
            rep = (delta >= thr);
          end
          if (rep && rate != 0) tbl_rep_rate[i] = rate;
          res = '{1'b0, tbl_key[i], rate, tbl_events[i], tbl_ignored[i], rep,
                  i == final_idx};
          pending_results.push_back(res);
          if (rate == 0 && tbl_rep_rate[i] == 0) tbl_valid[i] = 1'b0;
          else tbl_events[i] = '0;
        end
      end
    endcase
  endfunction

  // take valid down once the last word has gone
  task automatic drop_input();
    if (drive_on) begin
      in_valid <= 1'b0;
      drive_on = 1'b0;
    end
  endtask

  task automatic send_word(cmd_t cmd, logic [31:0] key, logic ign, logic [15:0] win,
                           bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      drop_input();
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_source_key <= key;
    in_ignored_in <= ign;
    in_window_ms <= win;
    drive_on = 1'b1;
    predict_rates(cmd, key, ign, win);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for the block to go quiet, then write the threshold
  task automatic set_min_delta(logic [31:0] value);
    drop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    min_delta_copy = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed();
    send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'd100);           // empty table
    send_word(CMD_RECORD, 32'h0000_0000, 1'b0, 16'hFFFF);
    send_word(CMD_RECORD, 32'hFFFF_FFFF, 1'b1, 16'h0);
    send_word(CMD_RECORD, 32'hFFFF_FFFF, 1'b0, 16'h0);
    send_word(CMD_SAMPLE, 32'hFFFF_FFFF, 1'b1, 16'h0);     // zero window
    send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'd1);
    send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'hFFFF);           // counts are zero: rates zero, entries freed
    send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'd10);             // table already empty
    send_word(CMD_FORGET, 32'h1234_5678, 1'b0, 16'd0);     // unknown key
    send_word(CMD_RECORD, 32'hA5A5_A5A5, 1'b1, 16'd0);
    send_word(CMD_FORGET, 32'hA5A5_A5A5, 1'b0, 16'd0);
    for (int i = 0; i < ENTRIES; i++)
      send_word(CMD_RECORD, 32'h100 + i, i[0], 16'd0);
    send_word(CMD_RECORD, 32'h5A5A_5A5A, 1'b1, 16'd0);     // table full
    send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'd3);
    send_word(CMD_CLEAR, 32'h0, 1'b0, 16'd0);
  endtask

  task automatic test_threshold_settings();
    logic [31:0] settings [4] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd300};
    foreach (settings[k]) begin
      set_min_delta(settings[k]);
      for (int round = 0; round < 3; round++) begin
        for (int e = 0; e < 3 + round * 2; e++)
          send_word(CMD_RECORD, key_pool[e % 4], e[0], 16'd0);
        send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'($urandom_range(1, 1500)));
      end
    end
    set_min_delta(32'd10);
  endtask

  task automatic test_random();
    int r;
    logic [31:0] key;
    logic [15:0] win;
    for (int n = 0; n < 155; n++) begin
      r = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
      if (r < 70) begin
        send_word(CMD_RECORD, key, 1'($urandom), 16'($urandom));
      end else if (r < 78) begin
        send_word(CMD_FORGET, key, 1'($urandom), 16'($urandom));
      end else if (r < 80) begin
        send_word(CMD_CLEAR, $urandom, 1'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(0, 5))
          0: win = 16'd0;
          1: win = 16'hFFFF;
          2: win = 16'($urandom);
          default: win = 16'($urandom_range(1, 2000));
        endcase
        send_word(CMD_SAMPLE, $urandom, 1'($urandom), win);
      end
    end
  endtask

  // stall the receiver while the sender keeps feeding a multi-result sample
  task automatic test_backpressure();
    drop_input();
    while (pending_results.size() != 0) @(posedge clk);
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 10; i++)
          send_word(CMD_RECORD, 32'h7000 + i, 1'b0, 16'd0, 1'b1);
        send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'd7, 1'b1);
        send_word(CMD_RECORD, 32'h7000, 1'b1, 16'd0, 1'b1);
        send_word(CMD_SAMPLE, 32'h0, 1'b0, 16'd7, 1'b1);
      end
    join
  endtask

  initial begin
    int waited;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_events[i] = '0;
      tbl_ignored[i] = 1'b0; tbl_rep_rate[i] = '0;
    end
    min_delta_copy = 32'd10;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold_settings();
    test_backpressure();
    test_random();
    drop_input();
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("per_source_rate_monitor_test: PASS");
    else
      $display("per_source_rate_monitor_test: FAIL");
    $finish;
  end

endmodule
